// ===== src/ddn_pkg.sv =====
// ----------------------------------------------------------------------------
// ddn_pkg
// shared types, constants and the month-start table of the date converter
// ----------------------------------------------------------------------------
`default_nettype none

package ddn_pkg;

  localparam logic        KIND_TO_SERIAL = 1'b0;
  localparam logic        KIND_TO_DATE   = 1'b1;

  localparam logic [11:0] YEAR_BASE      = 12'd1900;
  localparam logic [16:0] DAYS_YEAR      = 17'd365;
  localparam logic [16:0] DAYS_QUAD      = 17'd1461;
  localparam logic [8:0]  LEAP_DAY_IDX   = 9'd59;
  localparam logic [16:0] RANGE_LO       = 17'd2;
  localparam logic [16:0] RANGE_HI       = 17'd73109;
  localparam logic [19:0] SERIAL_MAX     = 20'd131071;

  // reciprocal of 1461 scaled by 2**27, exact for the quotient range used
  localparam logic [16:0] RECIP_QUAD     = 17'd91868;
  localparam int          RECIP_SHIFT    = 27;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_ctl_t;

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/ddn_fwd.sv =====
// ----------------------------------------------------------------------------
// ddn_fwd
// date to day number datapath, four register stages
// ----------------------------------------------------------------------------
`default_nettype none

module ddn_fwd (
  input  wire logic               clk,
  input  wire ddn_pkg::pipe_ctl_t ctl,
  input  wire logic [11:0]        year,
  input  wire logic [3:0]         month,
  input  wire logic [4:0]         day,
  output logic [16:0]             serial
);

  // stage 1
  logic [11:0] dt1, dt1_next;
  logic [3:0]  mi1, mi1_next;
  logic        leap1, leap1_next;
  logic [4:0]  day1;
  // stage 2
  logic [19:0] total2, total2_next;
  // stage 3
  logic [16:0] sat3, sat3_next;

  always_comb begin
    dt1_next = (year > ddn_pkg::YEAR_BASE) ? (year - ddn_pkg::YEAR_BASE) : 12'd0;
    if (month == 4'd0) begin
      mi1_next = 4'd0;
    end else if (month > 4'd12) begin
      mi1_next = 4'd11;
    end else begin
      mi1_next = month - 4'd1;
    end
    leap1_next = (year > ddn_pkg::YEAR_BASE) && (year[1:0] == 2'b00) && (mi1_next >= 4'd2);
  end

  always_comb begin
    logic [19:0] quarter;
    quarter = (dt1 == 12'd0) ? 20'd0 : 20'((dt1 - 12'd1) >> 2);
    total2_next = 20'(dt1) * 20'(ddn_pkg::DAYS_YEAR) + quarter
                + 20'(ddn_pkg::month_start(mi1)) + 20'(day1) + 20'd1 + 20'(leap1);
  end

  always_comb begin
    sat3_next = (total2 > ddn_pkg::SERIAL_MAX) ? 17'(ddn_pkg::SERIAL_MAX) : total2[16:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      dt1   <= dt1_next;
      mi1   <= mi1_next;
      leap1 <= leap1_next;
      day1  <= day;
    end
    if (ctl.s2) begin
      total2 <= total2_next;
    end
    if (ctl.s3) begin
      sat3 <= sat3_next;
    end
    if (ctl.s4) begin
      serial <= sat3;
    end
  end

endmodule

`default_nettype wire

// ===== src/ddn_rev.sv =====
// ----------------------------------------------------------------------------
// ddn_rev
// day number to date datapath, four register stages
// ----------------------------------------------------------------------------
`default_nettype none

module ddn_rev (
  input  wire logic               clk,
  input  wire ddn_pkg::pipe_ctl_t ctl,
  input  wire logic [16:0]        day_number,
  output logic [11:0]             year_val,
  output logic [3:0]              month_val,
  output logic [4:0]              day_val,
  output logic                    rng_val
);

  // stage 1
  logic        rng1, small1;
  logic [8:0]  e1;
  logic [16:0] f1;
  logic [16:0] e1_full;
  // stage 2
  logic        rng2, small2;
  logic [8:0]  e2;
  logic [16:0] f2;
  logic [5:0]  c2;
  logic [33:0] prod;
  // stage 3
  logic        rng3, leap3;
  logic [11:0] y3, y3_next;
  logic [8:0]  d03, d03_next;
  logic        leap3_next;
  // stage 4
  logic [3:0]  m4_next;
  logic [4:0]  dd4_next;

  assign e1_full = day_number - ddn_pkg::RANGE_LO;
  assign prod    = 34'(f1) * 34'(ddn_pkg::RECIP_QUAD);

  always_comb begin
    logic [16:0] quad_days;
    logic [10:0] r;
    logic [1:0]  k;
    logic [10:0] k_days;
    quad_days = 17'(c2) * ddn_pkg::DAYS_QUAD;
    r = 11'(f2 - quad_days);
    k = 2'(r >= 11'd365) + 2'(r >= 11'd730) + 2'(r >= 11'd1095);
    k_days = 11'(k) * 11'(ddn_pkg::DAYS_YEAR);
    if (small2) begin
      y3_next    = ddn_pkg::YEAR_BASE;
      d03_next   = e2;
      leap3_next = 1'b0;
    end else begin
      y3_next    = ddn_pkg::YEAR_BASE + 12'd1 + 12'({c2, 2'b00}) + 12'(k);
      d03_next   = 9'(r - k_days);
      leap3_next = (k == 2'd3);
    end
  end

  always_comb begin
    logic [8:0] d0a;
    logic [3:0] cnt;
    logic [8:0] dd;
    d0a = (leap3 && d03 > ddn_pkg::LEAP_DAY_IDX) ? d03 - 9'd1 : d03;
    cnt = 4'd0;
    for (int i = 1; i < 12; i++) begin
      cnt = cnt + 4'(d0a >= ddn_pkg::month_start(4'(i)));
    end
    dd = d0a - ddn_pkg::month_start(cnt) + 9'd1;
    if (dd < 9'd1) begin
      dd = 9'd1;
    end else if (dd > 9'd31) begin
      dd = 9'd31;
    end
    if (leap3 && d03 == ddn_pkg::LEAP_DAY_IDX) begin
      m4_next  = 4'd2;
      dd4_next = 5'd29;
    end else begin
      m4_next  = cnt + 4'd1;
      dd4_next = dd[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      rng1   <= (day_number >= ddn_pkg::RANGE_LO) && (day_number <= ddn_pkg::RANGE_HI);
      small1 <= e1_full < ddn_pkg::DAYS_YEAR;
      e1     <= e1_full[8:0];
      f1     <= e1_full - ddn_pkg::DAYS_YEAR;
    end
    if (ctl.s2) begin
      rng2   <= rng1;
      small2 <= small1;
      e2     <= e1;
      f2     <= f1;
      c2     <= prod[ddn_pkg::RECIP_SHIFT +: 6];
    end
    if (ctl.s3) begin
      rng3  <= rng2;
      y3    <= y3_next;
      d03   <= d03_next;
      leap3 <= leap3_next;
    end
    if (ctl.s4) begin
      rng_val   <= rng3;
      year_val  <= rng3 ? y3 : 12'd0;
      month_val <= rng3 ? m4_next : 4'd0;
      day_val   <= rng3 ? dd4_next : 5'd0;
    end
  end

endmodule

`default_nettype wire

// ===== src/date_day_number_converter.sv =====
// ----------------------------------------------------------------------------
// date_day_number_converter
// calendar date <-> serial day number, day 2 = 1 Jan 1900
// ----------------------------------------------------------------------------
// Four-stage pipeline: an item can be taken every cycle while in_stall is
// low, and its result passes stages one to four in order. Each stage holds
// its item until the next stage frees, so bubbles close up under a stall and
// in_stall rises only once all four stages are full. Kind 0 gives the day
// number (saturating at 131071), kind 1 gives year, month and day for numbers
// 2..73109 and zeros with in_range low otherwise. The reverse path's year
// split uses one 17x17 constant multiply in stage two.
`default_nettype none

module date_day_number_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [16:0] day_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      serial_out,
  output logic [11:0]      year_out,
  output logic [3:0]       month_out,
  output logic [4:0]       day_out,
  output logic             in_range
);

  ddn_pkg::pipe_ctl_t ctl;
  logic               adv1, adv2, adv3, adv4;
  logic               v1, v2, v3;
  logic               k1, k2, k3, k4;
  logic [16:0]        fwd_serial;
  logic [11:0]        rev_year;
  logic [3:0]         rev_month;
  logic [4:0]         rev_day;
  logic               rev_rng;

  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign ctl      = '{s1: adv1, s2: adv2, s3: adv3, s4: adv4};
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.s1) begin
        v1 <= in_valid;
      end
      if (ctl.s2) begin
        v2 <= v1;
      end
      if (ctl.s3) begin
        v3 <= v2;
      end
      if (ctl.s4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      k1 <= kind;
    end
    if (ctl.s2) begin
      k2 <= k1;
    end
    if (ctl.s3) begin
      k3 <= k2;
    end
    if (ctl.s4) begin
      k4 <= k3;
    end
  end

  ddn_fwd u_fwd (
    .clk    (clk),
    .ctl    (ctl),
    .year   (year),
    .month  (month),
    .day    (day),
    .serial (fwd_serial)
  );

  ddn_rev u_rev (
    .clk        (clk),
    .ctl        (ctl),
    .day_number (day_number),
    .year_val   (rev_year),
    .month_val  (rev_month),
    .day_val    (rev_day),
    .rng_val    (rev_rng)
  );

  always_comb begin
    if (k4 == ddn_pkg::KIND_TO_DATE) begin
      serial_out = 17'd0;
      year_out   = rev_year;
      month_out  = rev_month;
      day_out    = rev_day;
      in_range   = rev_rng;
    end else begin
      serial_out = fwd_serial;
      year_out   = 12'd0;
      month_out  = 4'd0;
      day_out    = 5'd0;
      in_range   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/ddn_checker.sv =====
// ----------------------------------------------------------------------------
// ddn_checker
// port-level checks of the date converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ddn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] serial_out,
  input wire logic [11:0] year_out,
  input wire logic [3:0]  month_out,
  input wire logic [4:0]  day_out,
  input wire logic        in_range
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(serial_out) && $stable(year_out)
      && $stable(month_out) && $stable(day_out) && $stable(in_range))
    else $error("stalled item changed");

  // out of range number gives an all-zero date
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> year_out == 12'd0 && month_out == 4'd0
      && day_out == 5'd0 && serial_out == 17'd0)
    else $error("out of range item not zero");

  // a date result has sane fields and no day number
  a_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && month_out != 4'd0 |-> in_range && serial_out == 17'd0
      && month_out <= 4'd12 && day_out >= 5'd1 && year_out >= 12'd1900)
    else $error("bad date result");

  // a day number result carries no date
  a_serial: assert property (@(posedge clk) disable iff (rst)
    out_valid && serial_out != 17'd0 |-> in_range && year_out == 12'd0
      && month_out == 4'd0 && day_out == 5'd0)
    else $error("day number result carries a date");

  // nothing shows right after reset
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind date_day_number_converter ddn_checker u_ddn_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date converter testbench
// drives dates and day numbers through both handshakes with random gaps,
// stalls and a long output hold, and compares every result with a table
// value or an in-bench model of the 1900-based calendar
// ----------------------------------------------------------------------------

module testbench;

  typedef struct packed {
    logic [16:0] serial;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic        ok;
  } date_res_t;

  typedef struct {
    logic        k;
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [16:0] n;
    bit          fixed;
    date_res_t   want;
  } probe_t;

  localparam int MONTH_FIRST [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int SERIAL_CAP = 131071;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 170;
  localparam int RANDOM_ITEMS = 630;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = ddn_pkg::KIND_TO_SERIAL;
  logic [11:0] year = '0;
  logic [3:0]  month = '0;
  logic [4:0]  day = '0;
  logic [16:0] day_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] serial_out;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic        in_range;

  date_res_t pending_dates [$];
  int        err_cnt = 0;
  int        idle_cnt = 0;
  bit        burst = 1'b0;

  probe_t probe_tab [24] = '{
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1900, 4'd1,  5'd1,  17'd0,      1'b1,
      '{17'd2, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1900, 4'd3,  5'd1,  17'd0,      1'b1,
      '{17'd61, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1899, 4'd3,  5'd1,  17'd0,      1'b1,
      '{17'd61, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd0,    4'd0,  5'd0,  17'd0,      1'b1,
      '{17'd1, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd4095, 4'd15, 5'd31, 17'd0,      1'b1,
      '{17'd131071, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd2099, 4'd12, 5'd31, 17'd0,      1'b1,
      '{17'd73050, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1904, 4'd2,  5'd29, 17'd0,      1'b1,
      '{17'd1521, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1904, 4'd3,  5'd1,  17'd0,      1'b0, '0},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd2000, 4'd13, 5'd5,  17'd0,      1'b0, '0},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1999, 4'd2,  5'd31, 17'd0,      1'b0, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd0,      1'b1, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd1,      1'b1, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd2,      1'b1,
      '{17'd0, 12'd1900, 4'd1, 5'd1, 1'b1}},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd73109,  1'b1,
      '{17'd0, 12'd2100, 4'd2, 5'd28, 1'b1}},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd73110,  1'b1, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd131071, 1'b1, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd1521,   1'b1,
      '{17'd0, 12'd1904, 4'd2, 5'd29, 1'b1}},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd1522,   1'b0, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd1520,   1'b0, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd366,    1'b0, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd367,    1'b0, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd0,    4'd0,  5'd0,  17'd1826,   1'b0, '0},
    '{ddn_pkg::KIND_TO_DATE,   12'd4095, 4'd15, 5'd31, 17'd60,     1'b0, '0},
    '{ddn_pkg::KIND_TO_SERIAL, 12'd1960, 4'd2,  5'd29, 17'd131071, 1'b0, '0}
  };

  date_day_number_converter u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .year       (year),
    .month      (month),
    .day        (day),
    .day_number (day_number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .serial_out (serial_out),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .in_range   (in_range)
  );

  always #2 clk = ~clk;

  function automatic date_res_t convert_date(input logic k, input logic [11:0] y,
                                             input logic [3:0] m, input logic [4:0] d,
                                             input logic [16:0] n);
    date_res_t res;
    int yrs, mi, tot, e, f, quad, rem, k4, yy, doy, mm, dd;
    bit leap;
    res = '0;
    if (k == ddn_pkg::KIND_TO_SERIAL) begin
      yrs = (y > 1900) ? int'(y) - 1900 : 0;
      mi = (m < 1) ? 0 : (m > 12) ? 11 : int'(m) - 1;
      tot = 365 * yrs + ((yrs > 0) ? (yrs - 1) / 4 : 0) + MONTH_FIRST[mi] + int'(d) + 1;
      if (y > 1900 && y[1:0] == 2'b00 && m > 2) tot = tot + 1;
      if (tot > SERIAL_CAP) tot = SERIAL_CAP;
      res.serial = tot[16:0];
      res.ok = 1'b1;
    end else if (n >= ddn_pkg::RANGE_LO && n <= ddn_pkg::RANGE_HI) begin
      e = int'(n) - 2;
      leap = 1'b0;
      if (e < 365) begin
        yy = 1900;
        doy = e;
      end else begin
        f = e - 365;
        quad = f / 1461;
        rem = f % 1461;
        k4 = rem / 365;
        if (k4 > 3) k4 = 3;
        yy = 1901 + 4 * quad + k4;
        doy = rem - 365 * k4;
        leap = (k4 == 3);
      end
      if (leap && doy == 59) begin
        mm = 2;
        dd = 29;
      end else begin
        if (leap && doy > 59) doy = doy - 1;
        mm = 1;
        while (mm < 12 && doy >= MONTH_FIRST[mm]) mm = mm + 1;
        dd = doy - MONTH_FIRST[mm - 1] + 1;
        if (dd < 1) dd = 1;
        if (dd > 31) dd = 31;
      end
      res.yr = yy[11:0];
      res.mo = mm[3:0];
      res.dy = dd[4:0];
      res.ok = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
    if (got !== want) begin
      $display("%0t ns %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic offer_item(input logic k, input logic [11:0] y, input logic [3:0] m,
                            input logic [4:0] d, input logic [16:0] n,
                            input bit fixed, input date_res_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    year <= y;
    month <= m;
    day <= d;
    day_number <= n;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(fixed ? want : convert_date(k, y, m, d, n));
  endtask

  // result check
  always @(posedge clk) begin
    date_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t ns unexpected item: expected none, actual %0d %0d-%0d-%0d in_range %0b",
                 $time, serial_out, year_out, month_out, day_out, in_range);
        err_cnt++;
      end else begin
        want = pending_dates.pop_front();
        check_field("serial_out", want.serial, serial_out);
        check_field("year_out", 17'(want.yr), 17'(year_out));
        check_field("month_out", 17'(want.mo), 17'(month_out));
        check_field("day_out", 17'(want.dy), 17'(day_out));
        check_field("in_range", 17'(want.ok), 17'(in_range));
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // output side
  initial begin
    int gap;
    int seen;
    bit held;
    seen = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && seen == HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      seen++;
    end
  end

  // input side
  initial begin
    int sel;
    logic        k;
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [16:0] n;
    date_res_t   fwd;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_tab[i])
      offer_item(probe_tab[i].k, probe_tab[i].y, probe_tab[i].m, probe_tab[i].d,
                 probe_tab[i].n, probe_tab[i].fixed, probe_tab[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = (i >= 300 && i < 380);
      if (i == 450) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0) @(posedge clk);
      end
      k = 1'($urandom);
      y = 12'($urandom);
      m = 4'($urandom);
      d = 5'($urandom);
      n = 17'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        y = 12'($urandom_range(1900, 2099));
        m = 4'($urandom_range(1, 12));
        d = 5'($urandom_range(1, 31));
      end
      if (sel < 40) begin
        k = ddn_pkg::KIND_TO_SERIAL;
      end else if (sel < 70) begin
        // round trip of a calendar date
        fwd = convert_date(ddn_pkg::KIND_TO_SERIAL, y, m, d, n);
        k = ddn_pkg::KIND_TO_DATE;
        n = fwd.serial;
        y = 12'($urandom);
      end else if (sel < 85) begin
        k = ddn_pkg::KIND_TO_DATE;
        n = 17'($urandom_range(ddn_pkg::RANGE_LO, ddn_pkg::RANGE_HI));
      end
      offer_item(k, y, m, d, n, 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
